// ===== hw/rtl/optu_pkg.sv =====
`default_nettype none
package optu_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int US_PER_TICK_DEF = 1000;

  localparam int TIME_W    = 64;
  localparam int OP_W      = 2;
  localparam int ID_W      = 4;
  localparam int US_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_UNINIT   = 2'd0,
    MODE_EXPIRED  = 2'd1,
    MODE_DEADLINE = 2'd2,
    MODE_INTERVAL = 2'd3
  } mode_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TINC,
    S_RD,
    S_SUM,
    S_CMP,
    S_ADV,
    S_CAN,
    S_DIV,
    S_QADD,
    S_INC1,
    S_ARMW,
    S_TEND
  } st_t;

  typedef struct packed {
    logic tgt;
    logic lf;
  } mem_we_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_INVAL    = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/optu_if.sv =====
`default_nettype none
interface optu_in_if;
  logic                        valid;
  logic                        ready;
  logic [optu_pkg::OP_W-1:0]   op;
  logic [optu_pkg::ID_W-1:0]   timer_id;
  logic                        periodic;
  logic [optu_pkg::US_W-1:0]   duration_us;

  modport source (output valid, output op, output timer_id, output periodic,
                  output duration_us, input ready);
  modport sink   (input valid, input op, input timer_id, input periodic,
                  input duration_us, output ready);
endinterface

interface optu_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [optu_pkg::ID_W-1:0]   fired_id;
  logic                        status;
  logic                        last;

  modport source (output valid, output kind, output fired_id, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input fired_id, input status,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/optu_alu.sv =====
`default_nettype none
module optu_alu (
  input  wire logic [optu_pkg::TIME_W-1:0] a,
  input  wire logic [optu_pkg::TIME_W-1:0] b,
  input  wire optu_pkg::alu_op_t           op,
  output logic      [optu_pkg::TIME_W-1:0] res,
  output logic                             carry
);

  logic [optu_pkg::TIME_W-1:0] b_sel;
  logic [optu_pkg::TIME_W:0]   sum;

  // subtract as a + ~b + 1, carry out set means a >= b
  always_comb begin
    b_sel = (op == optu_pkg::ALU_SUB) ? ~b : b;
    sum   = {1'b0, a} + {1'b0, b_sel} + {{optu_pkg::TIME_W{1'b0}}, (op == optu_pkg::ALU_SUB)};
    res   = sum[optu_pkg::TIME_W-1:0];
    carry = sum[optu_pkg::TIME_W];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/optu_slot_mem.sv =====
`default_nettype none
module optu_slot_mem #(
  parameter int NUM_SLOTS = optu_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire optu_pkg::mem_we_t                  we,
  input  wire logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] waddr,
  input  wire logic [optu_pkg::TIME_W-1:0]        wtgt,
  input  wire logic [optu_pkg::TIME_W-1:0]        wlf,
  input  wire logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] raddr,
  output logic      [optu_pkg::TIME_W-1:0]        rtgt,
  output logic      [optu_pkg::TIME_W-1:0]        rlf
);

  logic [optu_pkg::TIME_W-1:0] tgt_mem [NUM_SLOTS];
  logic [optu_pkg::TIME_W-1:0] lf_mem  [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we.tgt) begin
      tgt_mem[waddr] <= wtgt;
    end
    if (we.lf) begin
      lf_mem[waddr] <= wlf;
    end
    rtgt <= tgt_mem[raddr];
    rlf  <= lf_mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oneshot_periodic_timer_table.sv =====
// tick: bump the counter, scan every slot, compare armed ones, then hand off the last beat
// arm: the quotient by US_PER_TICK comes from a reciprocal product and one add
// one item at a time, in_ch.ready only when idle
// results leave through an output register; a full register stalls the scan
// synchronous active-low reset clears the tick counter and all slot modes to uninitialized
// slot target and last-fire memories are not cleared; they are read only once a slot is armed
`default_nettype none
module oneshot_periodic_timer_table #(
  parameter int NUM_SLOTS   = optu_pkg::NUM_SLOTS_DEF,
  parameter int US_PER_TICK = optu_pkg::US_PER_TICK_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  optu_in_if.sink     in_ch,
  optu_out_if.source  out_ch
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW    = optu_pkg::TIME_W;
  localparam int IW    = optu_pkg::ID_W;
  localparam int UW    = optu_pkg::US_W;
  localparam logic [SW-1:0]    LAST_IDX = SW'(NUM_SLOTS - 1);
  // floor(x / US_PER_TICK) = (x * RECIP) >> RECIP_SH, exact for every 32-bit x
  localparam int             RECIP_SH = UW + $clog2(US_PER_TICK);
  localparam logic [TW-1:0]  RECIP    = ((TW'(1) << RECIP_SH) + TW'(US_PER_TICK) - TW'(1))
                                        / TW'(US_PER_TICK);
  localparam logic [UW-1:0]  RECIP_LO = RECIP[UW-1:0];
  localparam logic           RECIP_HI = RECIP[UW];

  optu_pkg::st_t   state_r, state_nxt;
  logic [TW-1:0]   now_r, now_nxt;
  logic [IW-1:0]   id_r, id_nxt;
  logic            per_r, per_nxt;
  logic [UW-1:0]   q_r, q_nxt;
  logic [SW-1:0]   idx_r, idx_nxt;
  logic [TW-1:0]   thr_r, thr_nxt;
  logic [TW-1:0]   ticks_r, ticks_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic            pend_kind_r, pend_kind_nxt;
  logic [IW-1:0]   pend_id_r, pend_id_nxt;
  logic            pend_st_r, pend_st_nxt;
  logic            out_v_r, out_v_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [IW-1:0]   out_id_r, out_id_nxt;
  logic            out_st_r, out_st_nxt;
  logic            out_last_r, out_last_nxt;
  optu_pkg::mode_t mode_r [NUM_SLOTS];

  optu_pkg::mode_t mode_rd, mode_wdata;
  logic            mode_we;
  logic [SW-1:0]   mode_addr, id_slot;
  logic            accept, id_ok, out_free, push, push_last;

  logic [TW-1:0]     alu_a, alu_b, alu_res;
  optu_pkg::alu_op_t alu_op;
  logic              alu_carry;

  optu_pkg::mem_we_t mem_we;
  logic [TW-1:0]     mem_wtgt, mem_rtgt, mem_rlf;
  logic [SW-1:0]     mem_waddr;

  optu_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .res   (alu_res),
    .carry (alu_carry)
  );

  optu_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wtgt  (mem_wtgt),
    .wlf   (now_r),
    .raddr (idx_r),
    .rtgt  (mem_rtgt),
    .rlf   (mem_rlf)
  );

  assign in_ch.ready     = (state_r == optu_pkg::S_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign id_ok           = int'(in_ch.timer_id) < NUM_SLOTS;
  assign out_free        = !out_v_r || out_ch.ready;
  assign id_slot         = SW'(id_r);
  assign mode_addr       = (state_r == optu_pkg::S_CAN || state_r == optu_pkg::S_ARMW)
                           ? id_slot : idx_r;
  assign mode_rd         = mode_r[mode_addr];
  assign mem_waddr       = (state_r == optu_pkg::S_ARMW) ? id_slot : idx_r;

  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.status   = out_st_r;
  assign out_ch.last     = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      optu_pkg::S_IDLE: begin
        if (accept) begin
          case (optu_pkg::op_t'(in_ch.op))
            optu_pkg::OP_TICK:   state_nxt = optu_pkg::S_TINC;
            optu_pkg::OP_ARM:    state_nxt = (id_ok && in_ch.duration_us != '0)
                                             ? optu_pkg::S_DIV : optu_pkg::S_TEND;
            optu_pkg::OP_CANCEL: state_nxt = id_ok ? optu_pkg::S_CAN : optu_pkg::S_TEND;
            default:             state_nxt = optu_pkg::S_TEND;
          endcase
        end
      end
      optu_pkg::S_TINC: state_nxt = optu_pkg::S_RD;
      optu_pkg::S_RD: begin
        if (mode_rd == optu_pkg::MODE_DEADLINE || mode_rd == optu_pkg::MODE_INTERVAL) begin
          state_nxt = optu_pkg::S_SUM;
        end else begin
          state_nxt = optu_pkg::S_ADV;
        end
      end
      optu_pkg::S_SUM: state_nxt = optu_pkg::S_CMP;
      optu_pkg::S_CMP: begin
        if (!(alu_carry && pend_v_r && !out_free)) begin
          state_nxt = optu_pkg::S_ADV;
        end
      end
      optu_pkg::S_ADV:  state_nxt = (idx_r == LAST_IDX) ? optu_pkg::S_TEND : optu_pkg::S_RD;
      optu_pkg::S_CAN:  state_nxt = optu_pkg::S_TEND;
      optu_pkg::S_DIV:  state_nxt = optu_pkg::S_QADD;
      optu_pkg::S_QADD: state_nxt = optu_pkg::S_INC1;
      optu_pkg::S_INC1: state_nxt = optu_pkg::S_ARMW;
      optu_pkg::S_ARMW: state_nxt = optu_pkg::S_TEND;
      optu_pkg::S_TEND: begin
        if (!pend_v_r || out_free) begin
          state_nxt = optu_pkg::S_IDLE;
        end
      end
      default: state_nxt = optu_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_nxt       = now_r;
    id_nxt        = id_r;
    per_nxt       = per_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    thr_nxt       = thr_r;
    ticks_nxt     = ticks_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    pend_st_nxt   = pend_st_r;
    alu_a         = now_r;
    alu_b         = '0;
    alu_op        = optu_pkg::ALU_ADD;
    mem_we        = '0;
    mem_wtgt      = ticks_r;
    mode_we       = 1'b0;
    mode_wdata    = optu_pkg::MODE_EXPIRED;
    push          = 1'b0;
    push_last     = 1'b0;

    case (state_r)
      optu_pkg::S_IDLE: begin
        if (accept) begin
          id_nxt  = in_ch.timer_id;
          per_nxt = in_ch.periodic;
          q_nxt   = in_ch.duration_us;
          // rejected or unknown commands answer right away
          if ((in_ch.op == optu_pkg::OP_ARM && (!id_ok || in_ch.duration_us == '0)) ||
              (in_ch.op == optu_pkg::OP_CANCEL && !id_ok) ||
              (in_ch.op == optu_pkg::OP_RSVD)) begin
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = optu_pkg::KIND_STATUS;
            pend_id_nxt   = in_ch.timer_id;
            pend_st_nxt   = optu_pkg::ST_INVAL;
          end
        end
      end
      optu_pkg::S_TINC: begin
        alu_b   = TW'(1);
        now_nxt = alu_res;
        idx_nxt = '0;
      end
      optu_pkg::S_SUM: begin
        if (mode_rd == optu_pkg::MODE_INTERVAL) begin
          alu_a   = mem_rtgt;
          alu_b   = mem_rlf;
          thr_nxt = alu_res;
        end else begin
          thr_nxt = mem_rtgt;
        end
      end
      optu_pkg::S_CMP: begin
        alu_b  = thr_r;
        alu_op = optu_pkg::ALU_SUB;
        // hold one notice back so the final one can carry last
        if (alu_carry && (!pend_v_r || out_free)) begin
          mem_we.lf = 1'b1;
          if (mode_rd == optu_pkg::MODE_DEADLINE) begin
            mode_we = 1'b1;
          end
          push          = pend_v_r;
          pend_v_nxt    = 1'b1;
          pend_kind_nxt = optu_pkg::KIND_EXPIRY;
          pend_id_nxt   = IW'(idx_r);
          pend_st_nxt   = optu_pkg::ST_OK;
        end
      end
      optu_pkg::S_ADV: begin
        if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      optu_pkg::S_CAN: begin
        pend_v_nxt    = 1'b1;
        pend_kind_nxt = optu_pkg::KIND_STATUS;
        pend_id_nxt   = id_r;
        if (mode_rd == optu_pkg::MODE_UNINIT) begin
          pend_st_nxt = optu_pkg::ST_INVAL;
        end else begin
          pend_st_nxt = optu_pkg::ST_OK;
          mode_we     = 1'b1;
        end
      end
      optu_pkg::S_DIV: begin
        // 32 by 32 product with the low word of the reciprocal, parked in ticks_r
        ticks_nxt = TW'(q_r) * TW'(RECIP_LO);
      end
      optu_pkg::S_QADD: begin
        // add the reciprocal's top bit, then keep the quotient bits
        alu_a = ticks_r;
        alu_b = RECIP_HI ? {q_r, {UW{1'b0}}} : '0;
        q_nxt = UW'({alu_carry, alu_res} >> RECIP_SH);
      end
      optu_pkg::S_INC1: begin
        alu_a     = TW'(q_r);
        alu_b     = TW'(1);
        ticks_nxt = alu_res;
      end
      optu_pkg::S_ARMW: begin
        alu_b      = ticks_r;
        mem_we     = '{tgt: 1'b1, lf: 1'b1};
        mem_wtgt   = per_r ? ticks_r : alu_res;
        mode_we    = 1'b1;
        mode_wdata = per_r ? optu_pkg::MODE_INTERVAL : optu_pkg::MODE_DEADLINE;
        pend_v_nxt    = 1'b1;
        pend_kind_nxt = optu_pkg::KIND_STATUS;
        pend_id_nxt   = id_r;
        pend_st_nxt   = optu_pkg::ST_OK;
      end
      optu_pkg::S_TEND: begin
        if (pend_v_r && out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    out_v_nxt    = out_v_r;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_v_nxt    = 1'b1;
      out_kind_nxt = pend_kind_r;
      out_id_nxt   = pend_id_r;
      out_st_nxt   = pend_st_r;
      out_last_nxt = push_last;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= optu_pkg::S_IDLE;
      now_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        mode_r[s] <= optu_pkg::MODE_UNINIT;
      end
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (mode_we) begin
        mode_r[mode_addr] <= mode_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    per_r       <= per_nxt;
    q_r         <= q_nxt;
    idx_r       <= idx_nxt;
    thr_r       <= thr_nxt;
    ticks_r     <= ticks_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_st_r   <= pend_st_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_v_r)
    else $error("input ready while a result is still pending");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result beat pushed into a full output register");

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == optu_pkg::S_TINC) |=> (now_r == $past(now_r) + TW'(1)))
    else $error("tick counter did not advance by one");

  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == optu_pkg::S_DIV) |=> (state_r == optu_pkg::S_QADD))
    else $error("reciprocal product not followed by its high-part add");

endmodule
`default_nettype wire

// ===== sim/oneshot_periodic_timer_table_test.sv =====
`default_nettype none
module oneshot_periodic_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 190;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    optu_pkg::op_t op;
    logic [3:0]    timer_id;
    logic          periodic;
    logic [31:0]   duration_us;
    logic          drain_first;
  } timer_cmd_t;

  typedef struct {
    logic       kind;
    logic [3:0] fired_id;
    logic       status;
    logic       last;
  } timer_beat_t;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_style_t;

  logic clk;
  logic rst_n;

  optu_in_if  in_bus ();
  optu_out_if out_bus ();

  oneshot_periodic_timer_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  timer_cmd_t  cmd_queue[$];
  timer_beat_t notice_queue[$];
  int          error_count = 0;
  int          items_in = 0;

  // shadow copy of the timer table
  logic [63:0]     now_ticks = '0;
  optu_pkg::mode_t slot_state [optu_pkg::NUM_SLOTS_DEF] = '{default: optu_pkg::MODE_UNINIT};
  logic [63:0]     slot_due [optu_pkg::NUM_SLOTS_DEF] = '{default: '0};
  logic [63:0]     slot_fired_at [optu_pkg::NUM_SLOTS_DEF] = '{default: '0};

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_notice(input logic kind, input int id, input logic status);
    timer_beat_t b;
    b.kind     = kind;
    b.fired_id = id[3:0];
    b.status   = status;
    b.last     = 1'b1;
    notice_queue.push_back(b);
  endtask

  // updates the shadow table for one accepted item and queues its beats
  task automatic run_timer_cmd(input timer_cmd_t c);
    int          fired;
    logic        due;
    logic [63:0] ticks;
    fired = 0;
    case (c.op)
      optu_pkg::OP_TICK: begin
        now_ticks = now_ticks + 64'd1;
        for (int s = 0; s < optu_pkg::NUM_SLOTS_DEF; s++) begin
          due = 1'b0;
          if (slot_state[s] == optu_pkg::MODE_DEADLINE)
            due = now_ticks >= slot_due[s];
          else if (slot_state[s] == optu_pkg::MODE_INTERVAL)
            due = now_ticks >= slot_due[s] + slot_fired_at[s];
          if (due) begin
            slot_fired_at[s] = now_ticks;
            if (slot_state[s] == optu_pkg::MODE_DEADLINE)
              slot_state[s] = optu_pkg::MODE_EXPIRED;
            push_notice(optu_pkg::KIND_EXPIRY, s, optu_pkg::ST_OK);
            notice_queue[notice_queue.size()-1].last = 1'b0;
            fired++;
          end
        end
        if (fired > 0)
          notice_queue[notice_queue.size()-1].last = 1'b1;
      end
      optu_pkg::OP_ARM: begin
        if (c.duration_us == 32'd0) begin
          push_notice(optu_pkg::KIND_STATUS, c.timer_id, optu_pkg::ST_INVAL);
        end else begin
          ticks = {32'd0, c.duration_us} / 64'(optu_pkg::US_PER_TICK_DEF) + 64'd1;
          slot_fired_at[c.timer_id] = now_ticks;
          if (c.periodic) begin
            slot_due[c.timer_id]   = ticks;
            slot_state[c.timer_id] = optu_pkg::MODE_INTERVAL;
          end else begin
            slot_due[c.timer_id]   = now_ticks + ticks;
            slot_state[c.timer_id] = optu_pkg::MODE_DEADLINE;
          end
          push_notice(optu_pkg::KIND_STATUS, c.timer_id, optu_pkg::ST_OK);
        end
      end
      optu_pkg::OP_CANCEL: begin
        if (slot_state[c.timer_id] == optu_pkg::MODE_UNINIT) begin
          push_notice(optu_pkg::KIND_STATUS, c.timer_id, optu_pkg::ST_INVAL);
        end else begin
          slot_state[c.timer_id] = optu_pkg::MODE_EXPIRED;
          push_notice(optu_pkg::KIND_STATUS, c.timer_id, optu_pkg::ST_OK);
        end
      end
      default: push_notice(optu_pkg::KIND_STATUS, c.timer_id, optu_pkg::ST_INVAL);
    endcase
  endtask

  task automatic queue_cmd(input optu_pkg::op_t op, input int id, input logic periodic,
                           input logic [31:0] us, input logic drain_first);
    timer_cmd_t c;
    c.op          = op;
    c.timer_id    = id[3:0];
    c.periodic    = periodic;
    c.duration_us = us;
    c.drain_first = drain_first;
    cmd_queue.push_back(c);
  endtask

  function automatic logic [31:0] pick_duration();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return 32'd0;
    else if (roll < 15)
      return $urandom;
    else if (roll < 30)
      return $urandom_range(1, 999);
    else
      return $urandom_range(1, 8000);
  endfunction

  // driver: bursts of beats with random gaps
  timer_cmd_t cur_cmd = '{optu_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, 1'b0};
  int         gap_left = 0;
  int         burst_left = 0;

  always @(posedge clk) begin : drive_p
    logic fire;
    logic nxt_valid;
    fire      = in_bus.valid && in_bus.ready;
    nxt_valid = in_bus.valid && !fire;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (fire) begin
        run_timer_cmd(cur_cmd);
        items_in <= items_in + 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain_first && notice_queue.size() != 0)) begin
          cur_cmd   = cmd_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_bus.valid       <= nxt_valid;
    in_bus.op          <= cur_cmd.op;
    in_bus.timer_id    <= cur_cmd.timer_id;
    in_bus.periodic    <= cur_cmd.periodic;
    in_bus.duration_us <= cur_cmd.duration_us;
  end

  // receiver: changing stall style, plus one long hold-off
  sink_style_t stall_style = SINK_OPEN;
  int          pattern_age = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin : sink_p
    logic nxt_ready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else begin
      if (!long_hold_done && items_in >= 70) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        stall_style = sink_style_t'($urandom_range(0, 3));
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        case (stall_style)
          SINK_OPEN:   nxt_ready = 1'b1;
          SINK_COIN:   nxt_ready = 1'($urandom_range(0, 1));
          SINK_SPARSE: nxt_ready = (pattern_age % 4) == 0;
          default:     nxt_ready = $urandom_range(0, 7) != 0;
        endcase
      end
    end
    out_bus.ready <= nxt_ready;
  end

  always @(posedge clk) begin : check_p
    timer_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (notice_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d id=%0d status=%0d last=%0d",
                                  out_bus.kind, out_bus.fired_id, out_bus.status,
                                  out_bus.last));
      end else begin
        want = notice_queue.pop_front();
        if (out_bus.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_bus.kind, want.kind));
        if (out_bus.fired_id !== want.fired_id)
          report_mismatch($sformatf("fired_id %0d, want %0d", out_bus.fired_id,
                                    want.fired_id));
        if (out_bus.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d (id %0d)", out_bus.status,
                                    want.status, want.fired_id));
        if (out_bus.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d (id %0d)", out_bus.last,
                                    want.last, want.fired_id));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("oneshot_periodic_timer_table_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int roll;
    int made;
    int next_drain;
    rst_n = 1'b0;

    // directed: rejects, edges of the duration, overwrite, cancel cases
    queue_cmd(optu_pkg::OP_CANCEL, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_RSVD, 15, 1'b1, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 15, 1'b0, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 1, 1'b0, 32'd1, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 2, 1'b1, 32'd999, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 3, 1'b1, 32'd1000, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_CANCEL, 1, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_CANCEL, 15, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 3, 1'b0, 32'd2999, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 4, 1'b1, 32'h8000_0000, 1'b0);
    queue_cmd(optu_pkg::OP_RSVD, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_CANCEL, 2, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
    queue_cmd(optu_pkg::OP_ARM, 15, 1'b1, 32'd1, 1'b0);
    queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);

    // random: mostly arm/tick traffic, with a few full-table sweeps
    made       = 0;
    next_drain = 1;
    while (made < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // arm every slot short (zero is rejected); the ticks fire all
        for (int s = 0; s < optu_pkg::NUM_SLOTS_DEF; s++)
          queue_cmd(optu_pkg::OP_ARM, s, 1'b1, $urandom_range(0, 1999), 1'b0);
        for (int k = 0; k < 4; k++)
          queue_cmd(optu_pkg::OP_TICK, 0, 1'b0, 32'd0, 1'b0);
        made += optu_pkg::NUM_SLOTS_DEF + 4;
      end else begin
        if (roll < 45)
          queue_cmd(optu_pkg::OP_ARM, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                    pick_duration(), 1'b0);
        else if (roll < 85)
          queue_cmd(optu_pkg::OP_TICK, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                    $urandom, 1'b0);
        else if (roll < 97)
          queue_cmd(optu_pkg::OP_CANCEL, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                    $urandom, 1'b0);
        else
          queue_cmd(optu_pkg::OP_RSVD, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                    $urandom, 1'b0);
        made++;
      end
      // sender waits for all expected notices to drain before this command
      if (next_drain > 0 && made >= next_drain) begin
        cmd_queue[cmd_queue.size()-1].drain_first = 1'b1;
        next_drain = (next_drain == 1) ? 120 : 0;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_bus.valid) @(posedge clk);
    while (notice_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (error_count == 0)
      $display("oneshot_periodic_timer_table_test: done, clean");
    else
      $display("oneshot_periodic_timer_table_test: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
